// File: rtl/core/lsf_pkg.sv
`timescale 1ns / 1ps
package lsf_pkg;

    localparam int DEF_MAX_POINTS   = 1024;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // fraction bits of slope (Q16.16) and r_squared (Q1.16)
    localparam int FRAC_BITS = 16;
    // quotient magnitude kept by the divider before saturation
    localparam int QT_W = 34;
    localparam int RES_W = 32;
    localparam int R2_W = 17;
    localparam int ST_W = 2;

    localparam logic [QT_W-1:0] LIM_S32 = 34'h07FFFFFFF;
    localparam logic [QT_W-1:0] LIM_R2  = 34'h000010000;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_TOO_FEW = 2'd1;
    localparam logic [ST_W-1:0] ST_X_CONST = 2'd2;
    localparam logic [ST_W-1:0] ST_Y_CONST = 2'd3;

    localparam logic [3:0] MUL_NXX  = 4'd0;
    localparam logic [3:0] MUL_XX   = 4'd1;
    localparam logic [3:0] MUL_NYY  = 4'd2;
    localparam logic [3:0] MUL_YY   = 4'd3;
    localparam logic [3:0] MUL_NXY  = 4'd4;
    localparam logic [3:0] MUL_XY   = 4'd5;
    localparam logic [3:0] MUL_YXX  = 4'd6;
    localparam logic [3:0] MUL_XXY  = 4'd7;
    localparam logic [3:0] MUL_DEN  = 4'd8;
    localparam logic [3:0] MUL_SXY2 = 4'd9;

    localparam logic [1:0] DIV_MEAN  = 2'd0;
    localparam logic [1:0] DIV_SLOPE = 2'd1;
    localparam logic [1:0] DIV_ICPT  = 2'd2;
    localparam logic [1:0] DIV_R2    = 2'd3;

    typedef struct packed {
        logic            accum;
        logic            clear_sums;
        logic            res_clear;
        logic            set_status;
        logic [ST_W-1:0] status_val;
        logic            r2_one;
        logic            mul_start;
        logic [3:0]      mul_op;
        logic            div_start;
        logic [1:0]      div_op;
    } lsf_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic sxx_zero;
        logic syy_zero;
        logic mul_done;
        logic div_done;
    } lsf_sts_t;

endpackage

// File: rtl/core/lsf_mul.sv
`timescale 1ns / 1ps
// Shift-and-add multiplier, one multiplier bit per cycle, sign applied by the caller.
module lsf_mul #(
    parameter int OW = 56
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [OW-1:0] a,
    input  logic signed [OW-1:0] b,
    output logic                 done,
    output logic                 neg,
    output logic [2*OW-1:0]      prod
);
    localparam int PW    = 2 * OW;
    localparam int CNT_W = $clog2(OW + 1);

    logic [OW-1:0]    a_mag, b_mag;
    logic [PW-1:0]    ma_reg, ma_next, p_reg, p_next;
    logic [OW-1:0]    mb_reg, mb_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next, done_reg, done_next;

    assign a_mag = a[OW-1] ? $unsigned(~a + 1'b1) : $unsigned(a);
    assign b_mag = b[OW-1] ? $unsigned(~b + 1'b1) : $unsigned(b);

    always_comb
    begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        p_next    = p_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            ma_next  = PW'(a_mag);
            mb_next  = b_mag;
            p_next   = '0;
            neg_next = a[OW-1] ^ b[OW-1];
            cnt_next = CNT_W'(OW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (mb_reg[0])
            begin
                p_next = p_reg + ma_reg;
            end
            ma_next  = ma_reg << 1;
            mb_next  = mb_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        p_reg   <= p_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign prod = p_reg;

endmodule

// File: rtl/core/lsf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, then round half away from zero and saturate.
module lsf_div #(
    parameter int PW = 112
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [PW+lsf_pkg::FRAC_BITS-1:0] num,
    input  logic [PW-1:0]                       den,
    input  logic [lsf_pkg::QT_W-1:0]            lim,
    output logic                                done,
    output logic signed [lsf_pkg::RES_W-1:0]    result
);
    import lsf_pkg::*;

    localparam int DW    = PW + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    num_mag;
    logic [DW-1:0]    nr_reg, nr_next;
    logic [PW-1:0]    den_reg, den_next, rem_reg, rem_next;
    logic [QT_W-1:0]  q_reg, q_next, lim_reg, lim_next, val;
    logic             ovf_reg, ovf_next, neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next, rnd_reg, rnd_next, done_reg, done_next;
    logic [PW:0]      sh, rsub, rem2;
    logic             ge, inc, sat;
    logic [QT_W:0]    q_inc;

    assign num_mag = num[DW-1] ? $unsigned(~num + 1'b1) : $unsigned(num);
    assign sh      = {rem_reg, nr_reg[DW-1]};
    assign ge      = sh >= {1'b0, den_reg};
    assign rsub    = sh - {1'b0, den_reg};
    assign rem2    = {rem_reg, 1'b0};
    assign inc     = rem2 >= {1'b0, den_reg};
    assign q_inc   = {1'b0, q_reg} + (QT_W + 1)'(inc);
    assign sat     = ovf_reg | (q_reg > lim_reg);
    assign val     = sat ? lim_reg : q_reg;

    always_comb
    begin
        nr_next   = nr_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        lim_next  = lim_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        rnd_next  = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            nr_next  = num_mag;
            neg_next = num[DW-1];
            den_next = den;
            rem_next = '0;
            q_next   = '0;
            ovf_next = 1'b0;
            lim_next = num[DW-1] ? lim + 1'b1 : lim;
            cnt_next = CNT_W'(DW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? rsub[PW-1:0] : sh[PW-1:0];
            nr_next  = nr_reg << 1;
            q_next   = {q_reg[QT_W-2:0], ge};
            ovf_next = ovf_reg | q_reg[QT_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next = 1'b0;
                rnd_next = 1'b1;
            end
        end
        else if (rnd_reg)
        begin
            q_next    = q_inc[QT_W-1:0];
            ovf_next  = ovf_reg | q_inc[QT_W];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nr_reg  <= nr_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        lim_reg <= lim_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    assign done   = done_reg;
    assign result = neg_reg ? $signed(RES_W'(~val + 1'b1)) : $signed(RES_W'(val));

endmodule

// File: rtl/core/lsf_dpath.sv
`timescale 1ns / 1ps
// Accumulators, centered sums, shared multiplier and divider, result registers.
module lsf_dpath #(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lsf_pkg::lsf_cmd_t                cmd,
    output lsf_pkg::lsf_sts_t                sts,
    input  logic signed [SAMPLE_WIDTH-1:0]   x_value,
    input  logic signed [SAMPLE_WIDTH-1:0]   y_value,
    output logic signed [lsf_pkg::RES_W-1:0] slope,
    output logic signed [lsf_pkg::RES_W-1:0] intercept,
    output logic [lsf_pkg::R2_W-1:0]         r_squared,
    output logic [lsf_pkg::ST_W-1:0]         fit_status
);
    import lsf_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int LW = SW + CW;
    localparam int QW = 2 * SW + CW;
    localparam int OW = 2 * SW + 2 * CW + 2;
    localparam int PW = 2 * OW;
    localparam int DW = PW + FRAC_BITS;

    logic [CW-1:0]          count_reg;
    logic signed [LW-1:0]   sum_x_reg, sum_y_reg;
    logic signed [QW-1:0]   sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic signed [2*SW-1:0] pxx, pyy, pxy;
    logic signed [PW-1:0]   acc_reg, prod_s, acc_diff;
    logic signed [OW-1:0]   sxx_reg, syy_reg, sxy_reg;
    logic [PW-1:0]          rden_reg;
    logic signed [RES_W-1:0] slope_reg, icpt_reg;
    logic [R2_W-1:0]        r2_reg;
    logic [ST_W-1:0]        status_reg;

    logic signed [OW-1:0]   mul_a, mul_b;
    logic                   mul_done, mul_neg;
    logic [PW-1:0]          mul_prod;
    logic signed [DW-1:0]   div_num;
    logic [PW-1:0]          div_den;
    logic [QT_W-1:0]        div_lim;
    logic                   div_done;
    logic signed [RES_W-1:0] div_res;

    assign pxx = x_value * x_value;
    assign pyy = y_value * y_value;
    assign pxy = x_value * y_value;

    // accumulate one point; points beyond the capacity are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (cmd.clear_sums)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (cmd.accum && (count_reg < CW'(MAX_POINTS)))
        begin
            count_reg  <= count_reg + 1'b1;
            sum_x_reg  <= sum_x_reg + LW'(x_value);
            sum_y_reg  <= sum_y_reg + LW'(y_value);
            sum_xx_reg <= sum_xx_reg + QW'(pxx);
            sum_yy_reg <= sum_yy_reg + QW'(pyy);
            sum_xy_reg <= sum_xy_reg + QW'(pxy);
        end
    end

    always_comb
    begin
        case (cmd.mul_op)
            MUL_NXX:  begin mul_a = $signed(OW'(count_reg)); mul_b = OW'(sum_xx_reg); end
            MUL_XX:   begin mul_a = OW'(sum_x_reg);          mul_b = OW'(sum_x_reg);  end
            MUL_NYY:  begin mul_a = $signed(OW'(count_reg)); mul_b = OW'(sum_yy_reg); end
            MUL_YY:   begin mul_a = OW'(sum_y_reg);          mul_b = OW'(sum_y_reg);  end
            MUL_NXY:  begin mul_a = $signed(OW'(count_reg)); mul_b = OW'(sum_xy_reg); end
            MUL_XY:   begin mul_a = OW'(sum_x_reg);          mul_b = OW'(sum_y_reg);  end
            MUL_YXX:  begin mul_a = OW'(sum_y_reg);          mul_b = OW'(sum_xx_reg); end
            MUL_XXY:  begin mul_a = OW'(sum_x_reg);          mul_b = OW'(sum_xy_reg); end
            MUL_DEN:  begin mul_a = sxx_reg;                 mul_b = syy_reg;         end
            MUL_SXY2: begin mul_a = sxy_reg;                 mul_b = sxy_reg;         end
            default:  begin mul_a = '0;                      mul_b = '0;              end
        endcase
    end

    lsf_mul #(
        .OW (OW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .neg   (mul_neg),
        .prod  (mul_prod)
    );

    assign prod_s   = mul_neg ? $signed(~mul_prod + 1'b1) : $signed(mul_prod);
    assign acc_diff = mul_neg ? acc_reg + $signed(mul_prod) : acc_reg - $signed(mul_prod);

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            case (cmd.mul_op)
                MUL_XX:  sxx_reg  <= acc_diff[OW-1:0];
                MUL_YY:  syy_reg  <= acc_diff[OW-1:0];
                MUL_XY:  sxy_reg  <= acc_diff[OW-1:0];
                MUL_XXY: acc_reg  <= acc_diff;
                MUL_DEN: rden_reg <= mul_prod;
                default: acc_reg  <= prod_s;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_op)
            DIV_MEAN:
            begin
                div_num = DW'(sum_y_reg);
                div_den = PW'(count_reg);
                div_lim = LIM_S32;
            end
            DIV_SLOPE:
            begin
                div_num = DW'(sxy_reg) <<< FRAC_BITS;
                div_den = PW'($unsigned(sxx_reg));
                div_lim = LIM_S32;
            end
            DIV_ICPT:
            begin
                div_num = DW'(acc_reg);
                div_den = PW'($unsigned(sxx_reg));
                div_lim = LIM_S32;
            end
            default:
            begin
                div_num = DW'(acc_reg) <<< FRAC_BITS;
                div_den = rden_reg;
                div_lim = LIM_R2;
            end
        endcase
    end

    lsf_div #(
        .PW (PW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num    (div_num),
        .den    (div_den),
        .lim    (div_lim),
        .done   (div_done),
        .result (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.res_clear)
        begin
            slope_reg <= '0;
            icpt_reg  <= '0;
            r2_reg    <= '0;
        end
        else if (cmd.r2_one)
        begin
            r2_reg <= LIM_R2[R2_W-1:0];
        end
        else if (div_done)
        begin
            case (cmd.div_op)
                DIV_SLOPE: slope_reg <= div_res;
                DIV_R2:    r2_reg    <= div_res[R2_W-1:0];
                default:   icpt_reg  <= div_res;
            endcase
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_val;
        end
        else if (cmd.res_clear)
        begin
            status_reg <= ST_OK;
        end
    end

    assign sts.n_lt2    = count_reg < CW'(2);
    assign sts.sxx_zero = sxx_reg == '0;
    assign sts.syy_zero = syy_reg == '0;
    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;

    assign slope      = slope_reg;
    assign intercept  = icpt_reg;
    assign r_squared  = r2_reg;
    assign fit_status = status_reg;

endmodule

// File: rtl/core/lsf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accept points, then step the multiplier and divider through the fit.
module lsf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_point,
    output logic              busy,
    output logic              done,
    output lsf_pkg::lsf_cmd_t cmd,
    input  lsf_pkg::lsf_sts_t sts
);
    import lsf_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_NXX    = 5'd2;
    localparam logic [4:0] S_XX     = 5'd3;
    localparam logic [4:0] S_NYY    = 5'd4;
    localparam logic [4:0] S_YY     = 5'd5;
    localparam logic [4:0] S_NXY    = 5'd6;
    localparam logic [4:0] S_XY     = 5'd7;
    localparam logic [4:0] S_BRANCH = 5'd8;
    localparam logic [4:0] S_MEAN   = 5'd9;
    localparam logic [4:0] S_SLOPE  = 5'd10;
    localparam logic [4:0] S_YXX    = 5'd11;
    localparam logic [4:0] S_XXY    = 5'd12;
    localparam logic [4:0] S_ICPT   = 5'd13;
    localparam logic [4:0] S_YCHK   = 5'd14;
    localparam logic [4:0] S_DEN    = 5'd15;
    localparam logic [4:0] S_SXY2   = 5'd16;
    localparam logic [4:0] S_R2     = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       go_reg, go_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.status_val = ST_OK;
        cmd.mul_op     = MUL_NXX;
        cmd.div_op     = DIV_MEAN;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accum = start;
                if (start && last_point)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.res_clear = 1'b1;
                if (sts.n_lt2)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_TOO_FEW;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_NXX;
                end
            end
            S_NXX:
            begin
                cmd.mul_op = MUL_NXX;
                if (sts.mul_done) state_next = S_XX;
            end
            S_XX:
            begin
                cmd.mul_op = MUL_XX;
                if (sts.mul_done) state_next = S_NYY;
            end
            S_NYY:
            begin
                cmd.mul_op = MUL_NYY;
                if (sts.mul_done) state_next = S_YY;
            end
            S_YY:
            begin
                cmd.mul_op = MUL_YY;
                if (sts.mul_done) state_next = S_NXY;
            end
            S_NXY:
            begin
                cmd.mul_op = MUL_NXY;
                if (sts.mul_done) state_next = S_XY;
            end
            S_XY:
            begin
                cmd.mul_op = MUL_XY;
                if (sts.mul_done) state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (sts.sxx_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_X_CONST;
                    state_next     = S_MEAN;
                end
                else
                begin
                    state_next = S_SLOPE;
                end
            end
            S_MEAN:
            begin
                cmd.div_op = DIV_MEAN;
                if (sts.div_done) state_next = S_EMIT;
            end
            S_SLOPE:
            begin
                cmd.div_op = DIV_SLOPE;
                if (sts.div_done) state_next = S_YXX;
            end
            S_YXX:
            begin
                cmd.mul_op = MUL_YXX;
                if (sts.mul_done) state_next = S_XXY;
            end
            S_XXY:
            begin
                cmd.mul_op = MUL_XXY;
                if (sts.mul_done) state_next = S_ICPT;
            end
            S_ICPT:
            begin
                cmd.div_op = DIV_ICPT;
                if (sts.div_done) state_next = S_YCHK;
            end
            S_YCHK:
            begin
                if (sts.syy_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_Y_CONST;
                    cmd.r2_one     = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                cmd.mul_op = MUL_DEN;
                if (sts.mul_done) state_next = S_SXY2;
            end
            S_SXY2:
            begin
                cmd.mul_op = MUL_SXY2;
                if (sts.mul_done) state_next = S_R2;
            end
            S_R2:
            begin
                cmd.div_op = DIV_R2;
                if (sts.div_done) state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.clear_sums = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // kick the unit once, on the first cycle of its state
        case (state_reg)
            S_NXX, S_XX, S_NYY, S_YY, S_NXY, S_XY, S_YXX, S_XXY, S_DEN, S_SXY2:
                cmd.mul_start = go_reg;
            S_MEAN, S_SLOPE, S_ICPT, S_R2:
                cmd.div_start = go_reg;
            default:
                cmd.mul_start = 1'b0;
        endcase
    end

    assign go_next = state_next != state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_EMIT;

`ifndef NO_ASSERTIONS
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("fit did not return to idle after its result");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mul_start && cmd.div_start))
        else $error("multiplier and divider started together");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> !cmd.mul_start && !cmd.div_start)
        else $error("unit started while a product completes");

    a_accum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> !busy && !sts.mul_done && !sts.div_done)
        else $error("point accumulated while the fit runs");
`endif

endmodule

// File: rtl/core/least_squares_line_fit.sv
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// points    start in, busy out          x_value, y_value (Q8.8), last_point
// results   done out (one-cycle strobe) slope (Q16.16), intercept (Q24.8),
//                                       r_squared (Q1.16), fit_status
//
// A non-closing point is accumulated while idle; points can enter back to back.
// A closing point runs the fit: up to 10 serial products of OW-bit operands plus
// up to 3 serial divisions of a DW-bit numerator, with OW = 2*SAMPLE_WIDTH +
// 2*clog2(MAX_POINTS+1) + 2 and DW = 2*OW + 16; busy stays high meanwhile.
// rst_n clears the count, the running sums and the sequencer at once.
// The receiver cannot stall; results hold from done until the next fit clears them.
module least_squares_line_fit #(
    parameter int MAX_POINTS   = lsf_pkg::DEF_MAX_POINTS,
    parameter int SAMPLE_WIDTH = lsf_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [SAMPLE_WIDTH-1:0]   x_value,
    input  logic signed [SAMPLE_WIDTH-1:0]   y_value,
    input  logic                             last_point,
    output logic                             done,
    output logic signed [lsf_pkg::RES_W-1:0] slope,
    output logic signed [lsf_pkg::RES_W-1:0] intercept,
    output logic [lsf_pkg::R2_W-1:0]         r_squared,
    output logic [lsf_pkg::ST_W-1:0]         fit_status
);
    import lsf_pkg::*;

    // commands down to the datapath, status back up
    lsf_cmd_t cmd;
    lsf_sts_t sts;

    // sequencer: takes points while idle, then walks the fit and raises done
    lsf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_point (last_point),
        .busy       (busy),
        .done       (done),
        .cmd        (cmd),
        .sts        (sts)
    );

    // datapath: exact sums, centered sums, shared serial multiply and divide
    lsf_dpath #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .x_value    (x_value),
        .y_value    (y_value),
        .slope      (slope),
        .intercept  (intercept),
        .r_squared  (r_squared),
        .fit_status (fit_status)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for least_squares_line_fit.
// Sets of Q8.8 points go in one item at a time. A scoreboard class
// predicts each fit from exact running sums and checks every done strobe
// against the oldest pending fit, field by field.
module tb_top;
    import lsf_pkg::*;

    typedef struct {
        logic signed [RES_W-1:0] slope;
        logic signed [RES_W-1:0] intercept;
        logic [R2_W-1:0]         r_squared;
        logic [ST_W-1:0]         fit_status;
    } line_fit_t;

    // Scoreboard: holds its own copy of the count and sums, predicts each fit.
    class fit_scoreboard;
        int unsigned   pt_count;
        longint        acc_x, acc_y, acc_xx, acc_yy, acc_xy;
        line_fit_t     pending_fits[$];
        int            errors;

        function new();
            clear_sums();
            errors = 0;
        endfunction

        function void clear_sums();
            pt_count = 0;
            acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        endfunction

        // Divide, round half away from zero, saturate to 32-bit signed.
        function logic [31:0] div_round(logic signed [127:0] num, logic signed [127:0] den);
            logic                neg;
            logic signed [127:0] mag, q, r;
            neg = num < 0;
            mag = neg ? -num : num;
            q = mag / den;
            r = mag % den;
            if (2 * r >= den) q = q + 1;
            if (neg) begin
                if (q > 128'sd2147483648) q = 128'sd2147483648;
                return 32'(-q);
            end
            if (q > 128'sd2147483647) q = 128'sd2147483647;
            return 32'(q);
        endfunction

        function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
            line_fit_t           fit;
            logic signed [127:0] n, sx, sy, sxx_s, sxy_s, syy_s, sxx, syy, sxy;
            logic [127:0]        sxy_mag;
            logic [159:0]        num, den, q, r;
            longint              xl, yl;
            xl = 64'(x);
            yl = 64'(y);
            if (pt_count < 1024) begin
                pt_count++;
                acc_x += xl; acc_y += yl;
                acc_xx += xl * xl; acc_yy += yl * yl; acc_xy += xl * yl;
            end
            if (!last) return;
            fit.slope = 0; fit.intercept = 0; fit.r_squared = 0; fit.fit_status = ST_OK;
            n = 128'(pt_count);
            if (pt_count < 2) begin
                fit.fit_status = ST_TOO_FEW;
            end else begin
                sx = 128'(acc_x); sy = 128'(acc_y);
                sxx_s = 128'(acc_xx); syy_s = 128'(acc_yy); sxy_s = 128'(acc_xy);
                sxx = n * sxx_s - sx * sx;
                syy = n * syy_s - sy * sy;
                sxy = n * sxy_s - sx * sy;
                if (sxx == 0) begin
                    fit.fit_status = ST_X_CONST;
                    fit.intercept = div_round(sy, n);
                end else begin
                    fit.slope = div_round(sxy * 65536, sxx);
                    fit.intercept = div_round(sy * sxx_s - sx * sxy_s, sxx);
                    if (syy == 0) begin
                        fit.fit_status = ST_Y_CONST;
                        fit.r_squared = 17'd65536;
                    end else begin
                        sxy_mag = (sxy < 0) ? -sxy : sxy;
                        num = (160'(sxy_mag) * 160'(sxy_mag)) << 16;
                        den = 160'(sxx) * 160'(syy);
                        q = num / den;
                        r = num % den;
                        if (2 * r >= den) q = q + 1;
                        if (q > 160'd65536) q = 160'd65536;
                        fit.r_squared = 17'(q);
                    end
                end
            end
            pending_fits.push_back(fit);
            clear_sums();
        endfunction

        function void check_fit(line_fit_t got);
            line_fit_t want;
            if (pending_fits.size() == 0) begin
                $display("%0t: unexpected result slope=%0d", $time, got.slope);
                errors++;
                return;
            end
            want = pending_fits.pop_front();
            if (got.slope !== want.slope) begin
                $display("%0t: slope expected %0d actual %0d", $time, want.slope, got.slope);
                errors++;
            end
            if (got.intercept !== want.intercept) begin
                $display("%0t: intercept expected %0d actual %0d",
                         $time, want.intercept, got.intercept);
                errors++;
            end
            if (got.r_squared !== want.r_squared) begin
                $display("%0t: r_squared expected %0d actual %0d",
                         $time, want.r_squared, got.r_squared);
                errors++;
            end
            if (got.fit_status !== want.fit_status) begin
                $display("%0t: fit_status expected %0d actual %0d",
                         $time, want.fit_status, got.fit_status);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [15:0]       x_value = '0;
    logic signed [15:0]       y_value = '0;
    logic                     last_point = 1'b0;
    logic                     done;
    logic signed [RES_W-1:0]  slope;
    logic signed [RES_W-1:0]  intercept;
    logic [R2_W-1:0]          r_squared;
    logic [ST_W-1:0]          fit_status;

    fit_scoreboard sb = new();
    int            idle_cycles = 0;
    logic          took_item = 1'b0;

    least_squares_line_fit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .x_value    (x_value),
        .y_value    (y_value),
        .last_point (last_point),
        .done       (done),
        .slope      (slope),
        .intercept  (intercept),
        .r_squared  (r_squared),
        .fit_status (fit_status)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Check each done strobe; count cycles with no traffic for the watchdog.
    always @(posedge clk)
    begin
        line_fit_t got;
        if (rst_n) begin
            if (done) begin
                got.slope = slope;
                got.intercept = intercept;
                got.r_squared = r_squared;
                got.fit_status = fit_status;
                sb.check_fit(got);
            end
            if (done || took_item) idle_cycles = 0;
            else idle_cycles++;
            took_item = 1'b0;
            if (idle_cycles >= 20000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one point, hold it until accepted, then idle a random gap.
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
        int gap;
        x_value <= x;
        y_value <= y;
        last_point <= last;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        took_item = 1'b1;
        sb.note_point(x, y, last);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain: drop start and wait until every pending fit has come out.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_fits.size() != 0) @(posedge clk);
    endtask

    // Random set: draw a value style, then points with random content.
    task automatic send_random_set(int len);
        int                 mode;
        logic signed [15:0] x0, y0, x, y;
        mode = $urandom_range(0, 5);
        x0 = 16'($urandom);
        y0 = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            case (mode)
                1: begin x = x0 + $signed(16'($urandom_range(0, 15)) - 16'sd8);
                         y = y0 + $signed(16'($urandom_range(0, 15)) - 16'sd8); end
                2: x = x0;
                3: y = y0;
                4: y = 16'(x * 3 + $signed(16'($urandom_range(0, 3))));
                default: ;
            endcase
            send_point(x, y, i == len - 1);
        end
    endtask

    initial
    begin
        int items;
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // too few points
        send_point(16'sh7FFF, 16'sh8000, 1'b1);
        // two pairs of extreme points, the first pair saturates the slope
        send_point(16'sh0000, 16'sh8000, 1'b0);
        send_point(16'sh0001, 16'sh7FFF, 1'b1);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b1);
        // constant x
        send_point(16'sh1234, 16'sh0100, 1'b0);
        send_point(16'sh1234, 16'sh8000, 1'b0);
        send_point(16'sh1234, 16'sh0003, 1'b1);
        // constant y
        send_point(16'sh0100, 16'shFF00, 1'b0);
        send_point(16'sh8000, 16'shFF00, 1'b0);
        send_point(16'sh7FFF, 16'shFF00, 1'b1);
        // exact line
        send_point(16'sh0100, 16'sh0300, 1'b0);
        send_point(16'sh0200, 16'sh0500, 1'b0);
        send_point(16'shFF00, 16'shFF00, 1'b1);
        // pause until every pending fit is out
        wait_drained();

        // overflowing set: points past the limit are ignored
        for (int i = 0; i < 1030; i++)
            send_point(16'($urandom), 16'($urandom), i == 1029);
        wait_drained();

        items = 0;
        while (items < 700) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 30);
            send_random_set(len);
            items += len;
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (1200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_fits.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/lsf_pkg.sv
rtl/core/lsf_mul.sv
rtl/core/lsf_div.sv
rtl/core/lsf_dpath.sv
rtl/core/lsf_ctrl.sv
rtl/core/least_squares_line_fit.sv
dv/tb_top.sv
